// ----- rtl/lltd_pkg.sv -----
package lltd_pkg;

    localparam logic [1:0] REQ_NEW_TASK  = 2'd0;
    localparam logic [1:0] REQ_RESULT    = 2'd1;
    localparam logic [1:0] REQ_TERM_START = 2'd2;
    localparam logic [1:0] REQ_TERM_CONF = 2'd3;

    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_REFUSED     = 3'd1;
    localparam logic [2:0] STS_BAD_WORKER  = 3'd2;
    localparam logic [2:0] STS_UNDERFLOW   = 3'd3;
    localparam logic [2:0] STS_COUNT_FULL  = 3'd4;
    localparam logic [2:0] STS_UNEXP_CONF  = 3'd5;

    localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] worker_id;
    } lltd_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  chosen_worker;
        logic [19:0] total_outstanding;
        logic [4:0]  terminations_left;
        logic        any_in_progress;
    } lltd_rsp_t;

endpackage

// ----- rtl/lltd_ram.sv -----
module lltd_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/least_loaded_task_dispatcher.sv -----
// A new-task transaction reads the count of each of the N workers in use in S_SCAN, then
// passes S_WAIT to S_DECIDE; a result report reads its one count the same way. A refused
// new task and other requests go straight to S_DECIDE, which fills the result register.
// Requests wait until the last is done; the single read port scans one count per cycle.
// Reset clears the control state at once; entries never written read as zero through
// per-entry valid flags, so no clearing pass is needed and a request may enter right away.
module least_loaded_task_dispatcher
    import lltd_pkg::*;
#(
    parameter int MAX_WORKERS = 16,
    parameter int LOAD_BITS   = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  lltd_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output lltd_rsp_t rsp,
    input  logic      cfg_we,
    input  logic [4:0] cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_WORKERS);
    localparam logic [4:0] N_CAP = (MAX_WORKERS > 31) ? 5'd31 : 5'(MAX_WORKERS);
    localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [4:0]           cfg_reg;
    logic [4:0]           n_eff;
    logic [1:0]           req_type_reg, req_type_next;
    logic                 bad_reg, bad_next;
    logic [4:0]           n_reg, n_next;
    logic [4:0]           rd_idx_reg, rd_idx_next;
    logic [4:0]           cmp_idx_reg, cmp_idx_next;
    logic                 rd_pending_reg, rd_pending_next;
    logic                 rd_valid_reg;
    logic                 first_reg, first_next;
    logic [4:0]           best_reg, best_next;
    logic [LOAD_BITS-1:0] best_load_reg, best_load_next;
    logic [19:0]          load_total_reg, load_total_next;
    logic                 terminating_reg, terminating_next;
    logic [4:0]           pending_reg, pending_next;
    logic [MAX_WORKERS-1:0] valid_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    lltd_rsp_t            rsp_reg, rsp_next;
    logic                 out_free;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_raddr;
    logic [LOAD_BITS-1:0] ram_wdata;
    logic [LOAD_BITS-1:0] ram_rdata;
    logic [LOAD_BITS-1:0] load_seen;
    logic [2:0]           sts;
    logic [4:0]           chosen;

    lltd_ram #(
        .WIDTH (LOAD_BITS),
        .DEPTH (MAX_WORKERS)
    ) u_load_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n_eff = (cfg_reg == 5'd0) ? 5'd1 : ((cfg_reg > N_CAP) ? N_CAP : cfg_reg);
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign load_seen = rd_valid_reg ? ram_rdata : '0;
    assign ram_raddr = IDX_W'(rd_idx_reg);
    assign ram_waddr = IDX_W'(best_reg);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    always_comb
    begin
        state_next       = state_reg;
        req_type_next    = req_type_reg;
        bad_next         = bad_reg;
        n_next           = n_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        rd_pending_next  = 1'b0;
        first_next       = first_reg;
        best_next        = best_reg;
        best_load_next   = best_load_reg;
        load_total_next  = load_total_reg;
        terminating_next = terminating_reg;
        pending_next     = pending_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_next         = rsp_reg;
        ram_we           = 1'b0;
        ram_wdata        = '0;
        sts              = STS_OK;
        chosen           = 5'd0;

        if (rd_pending_reg && (first_reg || (load_seen < best_load_reg)))
        begin
            best_load_next = load_seen;
            best_next      = cmp_idx_reg;
            first_next     = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_type_next = req.req_type;
                    n_next        = n_eff;
                    bad_next      = (req.worker_id == 5'd0) || (req.worker_id > n_eff);
                    first_next    = 1'b1;
                    state_next    = S_DECIDE;
                    if (req.req_type == REQ_NEW_TASK && !terminating_reg)
                    begin
                        rd_idx_next = 5'd0;
                        state_next  = S_SCAN;
                    end
                    else if (req.req_type == REQ_RESULT && !bad_next)
                    begin
                        rd_idx_next = req.worker_id - 5'd1;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_pending_next = 1'b1;
                cmp_idx_next    = rd_idx_reg;
                if (req_type_reg == REQ_RESULT || rd_idx_reg == n_reg - 5'd1)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 5'd1;
                end
            end
            S_WAIT:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    unique case (req_type_reg)
                        REQ_NEW_TASK:
                        begin
                            if (terminating_reg)
                            begin
                                sts = STS_REFUSED;
                            end
                            else if (best_load_reg == LOAD_MAX || load_total_reg == TOTAL_MAX)
                            begin
                                sts = STS_COUNT_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_wdata       = best_load_reg + LOAD_BITS'(1);
                                load_total_next = load_total_reg + 20'd1;
                                chosen          = best_reg + 5'd1;
                            end
                        end
                        REQ_RESULT:
                        begin
                            if (bad_reg)
                            begin
                                sts = STS_BAD_WORKER;
                            end
                            else if (best_load_reg == '0 || load_total_reg == 20'd0)
                            begin
                                sts = STS_UNDERFLOW;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                ram_wdata       = best_load_reg - LOAD_BITS'(1);
                                load_total_next = load_total_reg - 20'd1;
                            end
                        end
                        REQ_TERM_START:
                        begin
                            terminating_next = 1'b1;
                            pending_next     = n_reg;
                        end
                        REQ_TERM_CONF:
                        begin
                            if (pending_reg == 5'd0)
                            begin
                                sts = STS_UNEXP_CONF;
                            end
                            else
                            begin
                                pending_next = pending_reg - 5'd1;
                            end
                        end
                    endcase
                    rsp_valid_next             = 1'b1;
                    rsp_next.status            = sts;
                    rsp_next.chosen_worker     = chosen;
                    rsp_next.total_outstanding = load_total_next;
                    rsp_next.terminations_left = pending_next;
                    rsp_next.any_in_progress   = (load_total_next != 20'd0)
                                                 || (pending_next != 5'd0);
                    state_next                 = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cfg_reg         <= 5'd16;
            rd_pending_reg  <= 1'b0;
            load_total_reg  <= 20'd0;
            terminating_reg <= 1'b0;
            pending_reg     <= 5'd0;
            valid_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_pending_reg  <= rd_pending_next;
            load_total_reg  <= load_total_next;
            terminating_reg <= terminating_next;
            pending_reg     <= pending_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg  <= req_type_next;
        bad_reg       <= bad_next;
        n_reg         <= n_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        rd_valid_reg  <= valid_reg[ram_raddr];
        first_reg     <= first_next;
        best_reg      <= best_next;
        best_load_reg <= best_load_next;
        rsp_reg       <= rsp_next;
    end

    a_write_only_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_DECIDE))
        else $error("Load memory written outside the decision step.");

    a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DECIDE) |=> $stable(load_total_reg))
        else $error("Total outstanding count changed outside the decision step.");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && req_type_reg == REQ_NEW_TASK) |-> (rd_idx_reg < n_reg))
        else $error("Load scan ran past the last worker in use.");

    a_chosen_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.chosen_worker != 5'd0) |-> (rsp.status == STS_OK))
        else $error("A worker was reported as chosen on a failed transaction.");

endmodule
